>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

>>> rtl/aes_cbc_pkg.sv
// Package for the AES-256 CBC block: types, constants, S-box and GF helpers.
// No dependencies.
`default_nettype none
package aes_cbc_pkg;
	localparam int NumRounds = 14;
	localparam int KeyWords = 4 * (NumRounds + 1);
	localparam int RkAw = 6;
	localparam int MaxBytes = 16;

	localparam logic [2:0] CfgKey0 = 3'd0;
	localparam logic [2:0] CfgKey1 = 3'd1;
	localparam logic [2:0] CfgKey2 = 3'd2;
	localparam logic [2:0] CfgKey3 = 3'd3;
	localparam logic [2:0] CfgIvHi = 3'd4;
	localparam logic [2:0] CfgIvLo = 3'd5;
	localparam logic [2:0] CfgMode = 3'd6;

	typedef enum logic [2:0] {
		ST_IDLE, ST_KEXP, ST_LOAD, ST_ROUND, ST_DONE
	} state_t;

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] x;
		r = 8'h00;
		x = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) r = r ^ x;
			x = xt(x);
		end
		return r;
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		return t[x];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction
endpackage
`default_nettype wire

>>> rtl/aes_cbc_ram.sv
// Generic single-port synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module aes_cbc_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] addr,
	input  wire logic [Width-1:0]         wdata,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

>>> rtl/aes_cbc_round.sv
// One AES round, forward or inverse, on a 128-bit state.
// Depends on aes_cbc_pkg.
`default_nettype none
module aes_cbc_round (
	input  wire logic         inverse,
	input  wire logic         last,
	input  wire logic [127:0] state_in,
	input  wire logic [127:0] round_key,
	output logic      [127:0] state_out
);
	import aes_cbc_pkg::*;

	logic [7:0] s [16];
	logic [7:0] t [16];
	logic [7:0] u [16];
	logic [7:0] m [16];
	logic [7:0] k [16];

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			s[i] = state_in[127-8*i -: 8];
			k[i] = round_key[127-8*i -: 8];
		end
		// forward: sub, shift, mix, key; inverse: shift, sub, key, mix
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				if (inverse) t[r + 4*((c + r) % 4)] = inv_sbox(s[r + 4*c]);
				else t[r + 4*c] = sbox(s[r + 4*((c + r) % 4)]);
			end
		end
		for (int i = 0; i < 16; i++)
			u[i] = inverse ? (t[i] ^ k[i]) : t[i];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inverse)
					m[4*c+r] = gmul(u[4*c+r], 8'd14) ^ gmul(u[4*c+(r+1)%4], 8'd11)
						^ gmul(u[4*c+(r+2)%4], 8'd13) ^ gmul(u[4*c+(r+3)%4], 8'd9);
				else
					m[4*c+r] = xt(u[4*c+r]) ^ xt(u[4*c+(r+1)%4]) ^ u[4*c+(r+1)%4]
						^ u[4*c+(r+2)%4] ^ u[4*c+(r+3)%4];
			end
		end
		for (int i = 0; i < 16; i++) begin
			if (last) state_out[127-8*i -: 8] = u[i] ^ (inverse ? 8'h00 : k[i]);
			else if (inverse) state_out[127-8*i -: 8] = m[i];
			else state_out[127-8*i -: 8] = m[i] ^ k[i];
		end
	end
endmodule
`default_nettype wire

>>> rtl/aes256_cbc_cipher_top.sv
// AES-256 CBC cipher top level: control, key expansion, round sequencing.
// Depends on aes_cbc_pkg, aes_cbc_ram, aes_cbc_round, assert_macros.svh.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one 128-bit block per beat as
//    block_hi/block_lo plus first_block and valid_bytes.
//  - Output channel (out_valid/out_ready) returns one 128-bit block per beat.
//  - Config port (cfg_we/cfg_index/cfg_data) writes key, IV and mode; write
//    only while the block is idle.
//  - Round keys live in four 16x32 RAM banks, 15 words used in each, so a whole
//    round key is read at once. Each round's key address is set in the cycle
//    before that round; the RAM read is registered.
//  - A normal block passes one load step and 14 rounds between acceptance and
//    out_valid. A first block first writes the 60 schedule words at one per
//    cycle, then fetches the first key.
//  - One block is in flight at a time; the chain of CBC feedback sets this.
//    After the result is taken, the block goes idle and in_ready rises again.
//    A finished result waits in the output register while the receiver
//    stalls; in_ready stays low until it is taken.
//  - Reset clears control state, the key, IV and mode registers, and the
//    chain. Round keys are undefined until the first block with first_block set.
`default_nettype none
`include "assert_macros.svh"
module aes256_cbc_cipher_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [63:0] block_hi,
	input  wire logic [63:0] block_lo,
	input  wire logic        first_block,
	input  wire logic [4:0]  valid_bytes,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      out_hi,
	output logic [63:0]      out_lo
);
	import aes_cbc_pkg::*;

	logic [63:0]  key_q [4];
	logic [127:0] iv_q;
	logic         mode_q;
	logic [127:0] chain_q;
	logic [127:0] state_q;
	logic [127:0] din_q;
	logic         dec_q;
	state_t       st_q, st_d;
	logic [5:0]   widx_q;      // schedule word index 0..59, then 60 for key fetch
	logic [31:0]  win_q [8];   // last eight schedule words
	logic [7:0]   rcon_q;
	logic [3:0]   rnd_q;       // rounds done

	// round key bank RAMs: bank b holds word 4*r+b at address r
	logic [3:0]   bank_we;
	logic [3:0]   ram_addr;
	logic [31:0]  bank_wd;
	logic [31:0]  bank_rd [4];
	logic [127:0] rkey;

	for (genvar b = 0; b < 4; b++) begin : g_bank
		aes_cbc_ram #(.Width(32), .Depth(16)) u_ram (
			.clk   (clk),
			.we    (bank_we[b]),
			.addr  (ram_addr),
			.wdata (bank_wd),
			.rdata (bank_rd[b])
		);
	end
	assign rkey = {bank_rd[0], bank_rd[1], bank_rd[2], bank_rd[3]};

	// key schedule step
	logic [31:0] prev_w, tw, new_w;
	always_comb begin
		prev_w = win_q[7];
		tw = prev_w;
		if (widx_q[2:0] == 3'd0) tw = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_q, 24'h0};
		else if (widx_q[2:0] == 3'd4) tw = sub_word(prev_w);
		new_w = win_q[0] ^ tw;
	end

	// which round key to fetch next
	logic [3:0] next_rk;
	logic       accept;
	assign accept = in_valid && in_ready;
	always_comb begin
		next_rk = 4'd0;
		if (st_q == ST_LOAD) next_rk = dec_q ? 4'd13 : 4'd1;
		else next_rk = dec_q ? 4'(13 - rnd_q - 1) : 4'(rnd_q + 2);
	end

	always_comb begin
		bank_we = 4'b0;
		bank_wd = new_w;
		ram_addr = next_rk;
		if (st_q == ST_KEXP) begin
			if (widx_q == 6'(KeyWords)) begin
				// schedule written; fetch the first round key
				ram_addr = dec_q ? 4'd14 : 4'd0;
			end else begin
				if (widx_q < 6'd8) begin
					bank_wd = win_q[widx_q[2:0]];
				end
				bank_we[widx_q[1:0]] = 1'b1;
				ram_addr = widx_q[5:2];
			end
		end else if (st_q == ST_IDLE || st_q == ST_DONE) begin
			ram_addr = (accept ? first_block : 1'b0) ? 4'd0
				: ((accept ? mode_q : dec_q) ? 4'd14 : 4'd0);
		end
	end

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:  if (accept) st_d = first_block ? ST_KEXP : ST_LOAD;
			ST_KEXP:  if (widx_q == 6'(KeyWords)) st_d = ST_LOAD;
			ST_LOAD:  st_d = ST_ROUND;
			ST_ROUND: if (rnd_q == 4'(NumRounds - 1)) st_d = ST_DONE;
			ST_DONE:  if (out_ready) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (st_q)
			ST_IDLE: in_ready = 1'b1;
			ST_DONE: out_valid = 1'b1;
			default: ;
		endcase
	end
	assign out_hi = state_q[127:64];
	assign out_lo = state_q[63:0];

	// padding mask for encryption
	logic [127:0] pad_mask;
	logic [4:0]   nval;
	always_comb begin
		nval = (valid_bytes == 5'd0 || valid_bytes > 5'(MaxBytes)) ? 5'(MaxBytes) : valid_bytes;
		for (int i = 0; i < 16; i++)
			pad_mask[127-8*i -: 8] = (5'(i) < nval) ? 8'hff : 8'h00;
	end

	logic [127:0] rnd_out;
	aes_cbc_round u_round (
		.inverse   (dec_q),
		.last      (rnd_q == 4'(NumRounds - 1)),
		.state_in  (state_q),
		.round_key (rkey),
		.state_out (rnd_out)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			key_q <= '{default: '0};
			iv_q <= '0;
			mode_q <= 1'b0;
			chain_q <= '0;
			widx_q <= '0;
			rnd_q <= '0;
			rcon_q <= 8'h01;
			dec_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				case (cfg_index)
					CfgKey0: key_q[0] <= cfg_data;
					CfgKey1: key_q[1] <= cfg_data;
					CfgKey2: key_q[2] <= cfg_data;
					CfgKey3: key_q[3] <= cfg_data;
					CfgIvHi: iv_q[127:64] <= cfg_data;
					CfgIvLo: iv_q[63:0] <= cfg_data;
					CfgMode: mode_q <= cfg_data[0];
					default: ;
				endcase
			end
			if (accept) begin
				dec_q <= mode_q;
				widx_q <= '0;
				rcon_q <= 8'h01;
				rnd_q <= '0;
				if (first_block) chain_q <= iv_q;
			end
			if (st_q == ST_KEXP) begin
				widx_q <= widx_q + 6'd1;
				if (widx_q >= 6'd8 && widx_q[2:0] == 3'd0) rcon_q <= xt(rcon_q);
			end
			if (st_q == ST_ROUND) begin
				rnd_q <= rnd_q + 4'd1;
				if (rnd_q == 4'(NumRounds - 1) && !dec_q) chain_q <= rnd_out;
				if (rnd_q == 4'(NumRounds - 1) && dec_q) chain_q <= din_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			din_q <= {block_hi, block_lo};
			state_q <= mode_q ? {block_hi, block_lo}
				: (({block_hi, block_lo} & pad_mask) ^ (first_block ? iv_q : chain_q));
			if (first_block)
				for (int i = 0; i < 8; i++) win_q[i] <= key_q[i/2][63-32*(i%2) -: 32];
		end
		// window holds words 0..7 until word 8 is built, then slides
		if (st_q == ST_KEXP && widx_q >= 6'd8) begin
			for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
			win_q[7] <= new_w;
		end
		if (st_q == ST_LOAD) state_q <= state_q ^ rkey;
		if (st_q == ST_ROUND) begin
			if (rnd_q == 4'(NumRounds - 1) && dec_q) state_q <= rnd_out ^ chain_q;
			else state_q <= rnd_out;
		end
	end

	`ASSERT_IMPL(a_one_side, clk, arst_n, 1'b1, !(in_ready && out_valid), "ready and valid overlap")
	`ASSERT_NEXT(a_hold_out, clk, arst_n, out_valid && !out_ready, out_valid && $stable(state_q),
		"result changed while stalled")
	`ASSERT_IMPL(a_kexp_range, clk, arst_n, st_q == ST_KEXP, widx_q <= 6'(KeyWords), "schedule overrun")
	`ASSERT_IMPL(a_round_range, clk, arst_n, st_q == ST_ROUND, rnd_q < 4'(NumRounds), "round overrun")
endmodule
`default_nettype wire
